[hw/rtl/page_frame_table_with_reference_sweep_unit_assert.svh]
// Assertion macros for the page frame table block.
// Used by the checker module; no other dependencies.
`ifndef PAGE_FRAME_TABLE_WITH_REFERENCE_SWEEP_UNIT_ASSERT_SVH
`define PAGE_FRAME_TABLE_WITH_REFERENCE_SWEEP_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pft check failed");
// Next-cycle implication.
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pft check failed");
`endif

[hw/rtl/pft_pkg.sv]
// Shared types and constants of the page frame table block.
// No dependencies.
package pft_pkg;
    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_LOAD   = 3'd1,
        CMD_MARK   = 3'd2,
        CMD_SWEEP  = 3'd3,
        CMD_SWAP   = 3'd4,
        CMD_FREE   = 3'd5,
        CMD_NOP6   = 3'd6,
        CMD_NOP7   = 3'd7
    } cmd_t;

    localparam logic [8:0] THRESH_RESET = 9'd25;
    localparam logic       ADDR_THRESH  = 1'b0;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] owner;
        logic [4:0] page_number;
        logic [7:0] frame_sel;
    } cmd_item_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] hit_frame;
        logic       free_found;
        logic [7:0] free_frame;
        logic       daemon_needed;
        logic [8:0] affected;
    } result_t;
endpackage

[hw/rtl/pft_cmd_queue.sv]
// Front queue of accepted commands between the port and the sweep engine.
// Depends on pft_pkg.
module pft_cmd_queue
    import pft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output cmd_item_t pop_item,
    output logic      empty
);
    cmd_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

[hw/rtl/pft_engine.sv]
// Back end: walks the frame store one entry per cycle to carry out a command.
// Depends on pft_pkg.
module pft_engine
    import pft_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int NUM_PROCS  = 32,
    parameter int NUM_PAGES  = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_item_t  cmd_item,
    output logic       cmd_take,
    input  logic [8:0] free_threshold,
    output logic       res_valid,
    output result_t    res_item,
    input  logic       res_take
);
    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);

    typedef enum logic [1:0] { S_CLEAR, S_IDLE, S_SCAN, S_DONE } state_t;

    logic       valid_mem [NUM_FRAMES];
    logic       refb_mem  [NUM_FRAMES];
    logic       evict_mem [NUM_FRAMES];
    logic [9:0] tag_mem   [NUM_FRAMES];

    logic       valid_rd_reg;
    logic       refb_rd_reg;
    logic       evict_rd_reg;
    logic [9:0] tag_rd_reg;

    state_t     state_reg;
    cmd_item_t  cur_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] free_cnt_reg;
    logic [8:0] aff_reg;
    logic       hit_reg;
    logic [7:0] hit_frame_reg;
    logic       ff_reg;
    logic [7:0] free_frame_reg;
    logic       res_valid_reg;
    result_t    res_reg;

    logic [9:0] tag;
    logic       v_now;
    logic       v_after;
    logic       own_ok;
    logic       page_ok;
    logic       sel_ok;
    logic       last;
    logic [7:0] idx8;
    logic [CW-1:0] cnt_next;
    logic [8:0] aff_next;
    logic       clr;
    logic       scan;
    logic       load_now;
    logic       mark_now;
    logic       load_here;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic       valid_we;
    logic       valid_wd;
    logic       refb_we;
    logic       refb_wd;
    logic       evict_we;
    logic       evict_wd;

    assign clr       = state_reg == S_CLEAR;
    assign scan      = state_reg == S_SCAN;
    assign tag       = tag_rd_reg;
    assign own_ok    = 32'(cur_reg.owner) < NUM_PROCS;
    assign page_ok   = 32'(cur_reg.page_number) < NUM_PAGES;
    assign sel_ok    = 32'(cur_reg.frame_sel) < NUM_FRAMES;
    assign last      = 32'(idx_reg) == NUM_FRAMES - 1;
    assign idx8      = 8'(idx_reg);
    assign load_here = cur_reg.command == CMD_LOAD && sel_ok && own_ok && page_ok
                       && IW'(cur_reg.frame_sel) == idx_reg;
    assign v_now     = valid_rd_reg || load_here;

    always_comb
    begin
        v_after  = v_now;
        aff_next = aff_reg;
        unique case (cur_reg.command)
            CMD_SWEEP:
            begin
                if (!refb_rd_reg)
                begin
                    aff_next = aff_reg + 9'd1;
                end
            end
            CMD_SWAP:
            begin
                if (evict_rd_reg)
                begin
                    v_after  = 1'b0;
                    aff_next = aff_reg + 9'd1;
                end
            end
            CMD_FREE:
            begin
                if (v_now && own_ok && tag[9:5] == cur_reg.owner)
                begin
                    v_after  = 1'b0;
                    aff_next = aff_reg + 9'd1;
                end
            end
            default:
            begin
            end
        endcase
        cnt_next = free_cnt_reg + CW'(!v_after);
    end

    assign cmd_take  = state_reg == S_IDLE && cmd_valid;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    assign load_now = cmd_take && cmd_item.command == CMD_LOAD
                      && 32'(cmd_item.frame_sel) < NUM_FRAMES
                      && 32'(cmd_item.owner) < NUM_PROCS
                      && 32'(cmd_item.page_number) < NUM_PAGES;
    assign mark_now = cmd_take && cmd_item.command == CMD_MARK
                      && 32'(cmd_item.frame_sel) < NUM_FRAMES;
    assign wr_addr  = (state_reg == S_IDLE) ? IW'(cmd_item.frame_sel) : idx_reg;
    assign rd_addr  = scan ? idx_reg + IW'(1) : '0;
    assign valid_we = clr || load_now || scan;
    assign valid_wd = load_now || (scan && v_after);
    assign refb_we  = clr || mark_now || (scan && cur_reg.command == CMD_SWEEP);
    assign refb_wd  = mark_now;
    assign evict_we = clr || mark_now
                      || (scan && (cur_reg.command == CMD_SWEEP || cur_reg.command == CMD_SWAP));
    assign evict_wd = scan && cur_reg.command == CMD_SWEEP && (evict_rd_reg || !refb_rd_reg);

    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[wr_addr] <= valid_wd;
        end
        if (refb_we)
        begin
            refb_mem[wr_addr] <= refb_wd;
        end
        if (evict_we)
        begin
            evict_mem[wr_addr] <= evict_wd;
        end
        if (load_now)
        begin
            tag_mem[wr_addr] <= {cmd_item.owner, cmd_item.page_number};
        end
        valid_rd_reg <= valid_mem[rd_addr];
        refb_rd_reg  <= refb_mem[rd_addr];
        evict_rd_reg <= evict_mem[rd_addr];
        tag_rd_reg   <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            res_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            idx_reg        <= '0;
            free_cnt_reg   <= '0;
            aff_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_frame_reg  <= '0;
            ff_reg         <= 1'b0;
            free_frame_reg <= '0;
            res_reg        <= '0;
        end
        else
        begin
            priority if (state_reg == S_DONE && (!res_valid_reg || res_take))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            else
            begin
                res_valid_reg <= res_valid_reg;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + IW'(1);
                    if (last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg        <= cmd_item;
                        idx_reg        <= '0;
                        free_cnt_reg   <= '0;
                        aff_reg        <= '0;
                        hit_reg        <= 1'b0;
                        hit_frame_reg  <= '0;
                        ff_reg         <= 1'b0;
                        free_frame_reg <= '0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cur_reg.command == CMD_LOOKUP && !hit_reg && v_now && own_ok
                        && page_ok && tag == {cur_reg.owner, cur_reg.page_number})
                    begin
                        hit_reg       <= 1'b1;
                        hit_frame_reg <= idx8;
                    end
                    if (!v_after && !ff_reg)
                    begin
                        ff_reg         <= 1'b1;
                        free_frame_reg <= idx8;
                    end
                    free_cnt_reg <= cnt_next;
                    aff_reg      <= aff_next;
                    idx_reg      <= idx_reg + IW'(1);
                    if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res_take)
                    begin
                        res_reg.hit            <= hit_reg;
                        res_reg.hit_frame      <= hit_frame_reg;
                        res_reg.free_found     <= ff_reg;
                        res_reg.free_frame     <= free_frame_reg;
                        res_reg.daemon_needed  <= 32'(free_cnt_reg) < 32'(free_threshold);
                        res_reg.affected       <= aff_reg;
                        state_reg              <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

[hw/rtl/page_frame_table_with_reference_sweep_unit.sv]
// One command at a time: the engine takes a new command only after storing the previous
// result, and walks the frame store one entry per cycle. A two-entry queue takes items
// during the walk.
// Reset: asynchronous, active low; clears queue and threshold (to 25), then a clearing pass
// over every frame zeroes valid, reference and evict bits before the first command starts.
// Owner/page tags are undefined until loaded.
module page_frame_table_with_reference_sweep_unit
    import pft_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int NUM_PROCS  = 32,
    parameter int NUM_PAGES  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [4:0]  owner,
    input  logic [4:0]  page_number,
    input  logic [7:0]  frame_sel,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [7:0]  hit_frame,
    output logic        free_found,
    output logic [7:0]  free_frame,
    output logic        daemon_needed,
    output logic [8:0]  affected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [8:0] thresh_reg;
    cmd_item_t  in_item;
    cmd_item_t  q_item;
    logic       q_empty;
    logic       q_take;
    logic       res_valid;
    result_t    res;

    assign in_item = '{command: command, owner: owner, page_number: page_number,
                       frame_sel: frame_sel};
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_THRESH) ? {23'd0, thresh_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_THRESH)
        begin
            thresh_reg <= pwdata[8:0];
        end
    end

    pft_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (full),
        .pop       (q_take),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    pft_engine #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_PROCS  (NUM_PROCS),
        .NUM_PAGES  (NUM_PAGES)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (!q_empty),
        .cmd_item       (q_item),
        .cmd_take       (q_take),
        .free_threshold (thresh_reg),
        .res_valid      (res_valid),
        .res_item       (res),
        .res_take       (pop)
    );

    assign empty         = !res_valid;
    assign hit           = res.hit;
    assign hit_frame     = res.hit_frame;
    assign free_found    = res.free_found;
    assign free_frame    = res.free_frame;
    assign daemon_needed = res.daemon_needed;
    assign affected      = res.affected;
endmodule

[hw/rtl/pft_checker.sv]
// Port-level checker for the page frame table block, bound to the top level.
// Depends on page_frame_table_with_reference_sweep_unit_assert.svh.
`include "page_frame_table_with_reference_sweep_unit_assert.svh"
module pft_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       hit,
    input logic [7:0] hit_frame,
    input logic       free_found,
    input logic [7:0] free_frame,
    input logic [8:0] affected,
    input logic       pready
);
    `PFT_ASSERT_IMPL(a_hit_frame_zero, clk, rst_n, !empty && !hit, hit_frame == 8'd0)
    `PFT_ASSERT_IMPL(a_free_frame_zero, clk, rst_n, !empty && !free_found, free_frame == 8'd0)
    `PFT_ASSERT_IMPL(a_hit_no_affect, clk, rst_n, !empty && hit, affected == 9'd0)
    `PFT_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(affected))
    `PFT_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind page_frame_table_with_reference_sweep_unit pft_checker u_pft_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .hit        (hit),
    .hit_frame  (hit_frame),
    .free_found (free_found),
    .free_frame (free_frame),
    .affected   (affected),
    .pready     (pready)
);
